@@ rtl/cqfs_pkg.sv @@
`timescale 1ns / 1ps

package cqfs_pkg;

  localparam int MAX_COLUMNS = 5;
  localparam int COL_W       = 3;
  localparam int DATA_W      = 8;
  localparam int MAX_RES     = 3;
  localparam int CNT_W       = 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COL_W-1:0]     MAX_COL    = COL_W'(MAX_COLUMNS);
  localparam logic [COL_W-1:0]     LAST_COL   = COL_W'(MAX_COLUMNS - 1);
  localparam logic [DATA_W-1:0]    DELIM_RST  = 8'd44;
  localparam logic [DATA_W-1:0]    QUOTE_RST  = 8'd34;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE  = 2'd1;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_LINE_DONE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [COL_W-1:0]   col;
    logic [DATA_W-1:0]  data;
  } result_t;

  // results caused by one input beat, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]        n;
    result_t [MAX_RES-1:0]   res;
  } group_t;

endpackage

@@ rtl/cqfs_front.sv @@
`timescale 1ns / 1ps

module cqfs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  input  logic [cqfs_pkg::DATA_W-1:0]     data_byte_i,
  input  logic                            line_end_i,
  input  logic                            cfg_valid_i,
  input  logic [cqfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cqfs_pkg::DATA_W-1:0]     cfg_data_i,
  output logic                            cfg_ready_o,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output cqfs_pkg::group_t                q_data_o
);

  logic [cqfs_pkg::DATA_W-1:0] delim_q, quote_q;
  logic                        inq_q, pend_q, fhb_q;
  logic [cqfs_pkg::COL_W-1:0]  col_q;

  logic                        inq_d, pend_d, fhb_d;
  logic [cqfs_pkg::COL_W-1:0]  col_d;
  logic [cqfs_pkg::CNT_W-1:0]  n;
  logic                        handled, is_q, is_d, accept;
  cqfs_pkg::group_t            grp;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !q_full_i;

  always_comb begin
    grp     = '0;
    n       = '0;
    inq_d   = inq_q;
    pend_d  = 1'b0;
    col_d   = col_q;
    fhb_d   = fhb_q;
    handled = 1'b0;
    is_q    = (data_byte_i == quote_q);
    is_d    = (data_byte_i == delim_q);

    // quote seen inside quotes: doubled quote or end of quoting
    if (pend_q) begin
      if (is_q) begin
        fhb_d   = 1'b1;
        handled = 1'b1;
        if (col_d < cqfs_pkg::MAX_COL) begin
          grp.res[0] = '{kind: cqfs_pkg::KIND_BYTE, col: col_d, data: quote_q};
          n = 2'd1;
        end
      end else begin
        inq_d = 1'b0;
      end
    end

    if (!handled) begin
      if (is_q) begin
        if (inq_d) pend_d = 1'b1;
        else       inq_d  = 1'b1;
      end else if (is_d && !inq_d) begin
        if (col_d < cqfs_pkg::MAX_COL) begin
          grp.res[0] = '{kind: cqfs_pkg::KIND_FIELD_END, col: col_d, data: '0};
          n     = 2'd1;
          col_d = col_d + cqfs_pkg::COL_W'(1);
        end
        fhb_d = 1'b0;
      end else begin
        fhb_d = 1'b1;
        if (col_d < cqfs_pkg::MAX_COL) begin
          grp.res[0] = '{kind: cqfs_pkg::KIND_BYTE, col: col_d, data: data_byte_i};
          n = 2'd1;
        end
      end
    end

    if (line_end_i) begin
      if (col_d < cqfs_pkg::MAX_COL && (fhb_d || col_d == cqfs_pkg::LAST_COL)) begin
        grp.res[n] = '{kind: cqfs_pkg::KIND_FIELD_END, col: col_d, data: '0};
        n = n + 2'd1;
      end
      grp.res[n] = '{kind: cqfs_pkg::KIND_LINE_DONE, col: '0, data: '0};
      n      = n + 2'd1;
      inq_d  = 1'b0;
      pend_d = 1'b0;
      col_d  = '0;
      fhb_d  = 1'b0;
    end
    grp.n = n;
  end

  assign q_push_o = accept && (n != '0);
  assign q_data_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= cqfs_pkg::DELIM_RST;
      quote_q <= cqfs_pkg::QUOTE_RST;
      inq_q   <= 1'b0;
      pend_q  <= 1'b0;
      col_q   <= '0;
      fhb_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == cqfs_pkg::CFG_DELIM) delim_q <= cfg_data_i;
        if (cfg_index_i == cqfs_pkg::CFG_QUOTE) quote_q <= cfg_data_i;
      end
      if (accept) begin
        inq_q  <= inq_d;
        pend_q <= pend_d;
        col_q  <= col_d;
        fhb_q  <= fhb_d;
      end
    end
  end

endmodule

@@ rtl/cqfs_queue.sv @@
`timescale 1ns / 1ps

module cqfs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cqfs_pkg::group_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output cqfs_pkg::group_t  data_o
);

  cqfs_pkg::group_t                 mem_q [cqfs_pkg::QDEPTH];
  logic [cqfs_pkg::QPTR_W-1:0]      wr_q, rd_q;
  logic [cqfs_pkg::QPTR_W:0]        cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == (cqfs_pkg::QPTR_W+1)'(cqfs_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + cqfs_pkg::QPTR_W'(1);
      if (do_pop)  rd_q <= rd_q + cqfs_pkg::QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (cqfs_pkg::QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (cqfs_pkg::QPTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/cqfs_back.sv @@
`timescale 1ns / 1ps

module cqfs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  cqfs_pkg::group_t              q_data_i,
  output logic                          q_pop_o,
  input  logic                          pop,
  output logic                          empty,
  output logic [1:0]                    out_kind_o,
  output logic [cqfs_pkg::COL_W-1:0]    column_index_o,
  output logic [cqfs_pkg::DATA_W-1:0]   out_byte_o,
  output logic                          last_of_run_o
);

  logic                         out_valid_q;
  cqfs_pkg::result_t            out_q;
  logic                         last_q;
  logic [cqfs_pkg::CNT_W-1:0]   idx_q;
  logic                         load, is_last;
  cqfs_pkg::result_t            cur;

  assign load    = q_valid_i && (!out_valid_q || pop);
  assign cur     = q_data_i.res[idx_q];
  assign is_last = (idx_q == q_data_i.n - cqfs_pkg::CNT_W'(1));
  assign q_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + cqfs_pkg::CNT_W'(1);
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q  <= cur;
      last_q <= is_last;
    end
  end

  assign empty          = !out_valid_q;
  assign out_kind_o     = out_q.kind;
  assign column_index_o = out_q.col;
  assign out_byte_o     = out_q.data;
  assign last_of_run_o  = last_q;

endmodule

@@ rtl/csv_quoted_field_splitter.sv @@
`timescale 1ns / 1ps

// CSV field splitter with quote handling.
// Input queue side: present data_byte_i / line_end_i with push; a beat is
// taken at a clock edge where push is high and full is low. Bytes are
// classified at once against the delimiter and quote registers.
// Result queue side: while empty is low the oldest result sits on
// out_kind_o / column_index_o / out_byte_o / last_of_run_o; pop takes it.
// Config: cfg_valid_i with cfg_index_i (0 delimiter, 1 quote) and
// cfg_data_i; cfg_ready_o is always high, write only while idle.
// Throughput: one input beat per cycle while full is low, one result
// beat per cycle while pop is high and results wait. A line-end byte can
// give up to three results; a 4-entry group queue between front and back
// absorbs those, so full rises only when results are produced faster than
// they are drained. Results are registered before they reach the outputs.
// Reset: parser state cleared, delimiter ',' and quote '"', queues empty.
// A stalled result holds its value until popped; upstream sees full once
// the group queue fills.
module csv_quoted_field_splitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [cqfs_pkg::DATA_W-1:0]     data_byte_i,
  input  logic                            line_end_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cqfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cqfs_pkg::DATA_W-1:0]     cfg_data_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      out_kind_o,
  output logic [cqfs_pkg::COL_W-1:0]      column_index_o,
  output logic [cqfs_pkg::DATA_W-1:0]     out_byte_o,
  output logic                            last_of_run_o
);

  logic             q_push, q_full, q_valid, q_pop;
  cqfs_pkg::group_t q_wdata, q_rdata;

  assign full = q_full;

  cqfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .data_byte_i (data_byte_i),
    .line_end_i  (line_end_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  cqfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  cqfs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_kind_o     (out_kind_o),
    .column_index_o (column_index_o),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

@@ rtl/cqfs_checker.sv @@
`timescale 1ns / 1ps

module cqfs_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [1:0]                    out_kind_o,
  input  logic [cqfs_pkg::COL_W-1:0]    column_index_o,
  input  logic [cqfs_pkg::DATA_W-1:0]   out_byte_o,
  input  logic                          last_of_run_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_kind_o) && $stable(column_index_o)
                       && $stable(out_byte_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  // line done closes the run of its byte, column zero
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_kind_o == cqfs_pkg::KIND_LINE_DONE |->
      last_of_run_o && column_index_o == '0 && out_byte_o == '0)
    else $error("bad line done beat");

  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_kind_o == cqfs_pkg::KIND_FIELD_END |-> out_byte_o == '0)
    else $error("field end carries data");

  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> column_index_o < cqfs_pkg::MAX_COL)
    else $error("column out of range");

endmodule

bind csv_quoted_field_splitter cqfs_checker u_cqfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .out_kind_o     (out_kind_o),
  .column_index_o (column_index_o),
  .out_byte_o     (out_byte_o),
  .last_of_run_o  (last_of_run_o)
);
